[src/sector_to_block_read_splitter_core_assert.svh]
// Assertion macros for the sector-to-block read splitter.
// Used by sector_to_block_read_splitter_core; no other dependencies.
`ifndef SECTOR_TO_BLOCK_READ_SPLITTER_CORE_ASSERT_SVH
`define SECTOR_TO_BLOCK_READ_SPLITTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define S2B_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("splitter assertion failed");
`define S2B_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("splitter forbidden condition seen");
`else
`define S2B_ASSERT(lbl, clk, rst, prop)
`define S2B_ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

[src/s2b_pkg.sv]
// Types, codes and microcode table for the sector-to-block read splitter.
// No dependencies.
`default_nettype none
package s2b_pkg;

   localparam int SECTOR_SHIFT = 9;

   typedef enum logic [1:0] {
      CSR_DEVICE_PRESENT = 2'd0,
      CSR_MEDIA_BSIZE    = 2'd1,
      CSR_MEDIA_BLOCKS   = 2'd2,
      CSR_TOTAL_SECTORS  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_BLOCK  = 2'd0,
      STATUS_REJECT = 2'd1,
      STATUS_BEYOND = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      STEP_IDLE   = 5'b00001,
      STEP_CHECK  = 5'b00010,
      STEP_DIV    = 5'b00100,
      STEP_EMIT   = 5'b01000,
      STEP_REJECT = 5'b10000
   } step_type;

   typedef enum logic [2:0] {
      COND_ALWAYS   = 3'd0,
      COND_START    = 3'd1,
      COND_BAD      = 3'd2,
      COND_DIV_MORE = 3'd3,
      COND_RUN_MORE = 3'd4
   } cond_type;

   typedef struct packed {
      logic     busy;
      logic     div_init;
      logic     div_step;
      logic     emit_blk;
      logic     emit_rej;
      cond_type cond;
      step_type jmp;
      step_type nxt;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type w;
      w.busy     = 1'b1;
      w.div_init = 1'b0;
      w.div_step = 1'b0;
      w.emit_blk = 1'b0;
      w.emit_rej = 1'b0;
      w.cond     = COND_ALWAYS;
      w.jmp      = STEP_IDLE;
      w.nxt      = STEP_IDLE;
      unique case (step)
         STEP_IDLE: begin
            w.busy = 1'b0;
            w.cond = COND_START;
            w.jmp  = STEP_CHECK;
            w.nxt  = STEP_IDLE;
         end
         STEP_CHECK: begin
            w.div_init = 1'b1;
            w.cond     = COND_BAD;
            w.jmp      = STEP_REJECT;
            w.nxt      = STEP_DIV;
         end
         STEP_DIV: begin
            w.div_step = 1'b1;
            w.cond     = COND_DIV_MORE;
            w.jmp      = STEP_DIV;
            w.nxt      = STEP_EMIT;
         end
         STEP_EMIT: begin
            w.emit_blk = 1'b1;
            w.cond     = COND_RUN_MORE;
            w.jmp      = STEP_EMIT;
            w.nxt      = STEP_IDLE;
         end
         STEP_REJECT: begin
            w.emit_rej = 1'b1;
         end
         default: begin
            w.busy = 1'b0;
         end
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

[src/sector_to_block_read_splitter_core.sv]
// Sector-to-block read splitter: microcoded sequencer with divider and emitter.
// Depends on s2b_pkg and sector_to_block_read_splitter_core_assert.svh.
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+-------------------------
//  request   | start, busy, req_start_sector/count     | taken when start & !busy
//  result    | rsp_valid, rsp_block_number ... last    | one-cycle strobe
//  registers | csr_valid, csr_ready, csr_index, wdata  | valid & ready
//
// A valid request holds busy through the check step, a 32-step restoring division by
// the block size in sectors, and one emit step per block; the idle step then follows
// before the next request can be taken.
// A rejected request holds busy through the check and reject steps, then returns to idle.
// Each result shows in the cycle after its step. Results cannot be stalled.
// Synchronous reset returns the sequencer to idle and registers to defaults.
`default_nettype none
`include "sector_to_block_read_splitter_core_assert.svh"
module sector_to_block_read_splitter_core #(
   parameter int MAX_SECTORS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_start_sector,
   input  wire logic [6:0]  req_sector_count,
   output logic             rsp_valid,
   output logic [31:0]      rsp_block_number,
   output logic [15:0]      rsp_byte_offset,
   output logic [15:0]      rsp_byte_take,
   output logic [1:0]       rsp_status,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int RW = $clog2(MAX_SECTORS + 1);

   s2b_pkg::step_type      step_ff, step_in;
   s2b_pkg::ctrl_word_type word;
   logic                   cond_hit;

   logic        dev_ff;
   logic [16:0] bsize_ff;
   logic [31:0] bcount_ff;
   logic [31:0] total_ff;

   logic [31:0] start_ff;
   logic [6:0]  count_ff;

   logic [31:0] q_ff, q_in;
   logic [6:0]  r_ff, r_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [RW-1:0] rem_ff, rem_in;

   logic [7:0]  m_sec;
   logic        bs_bad;
   logic [32:0] end_sum;
   logic        bad;
   logic [7:0]  shifted;
   logic        ge;
   logic [7:0]  avail;
   logic [7:0]  rem_ext;
   logic [7:0]  take8;
   logic [RW-1:0] take;
   logic        beyond;
   logic        run_end;
   logic        accept;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         rsp_block_ff, rsp_block_in;
   logic [15:0]         rsp_offset_ff, rsp_offset_in;
   logic [15:0]         rsp_take_ff, rsp_take_in;
   s2b_pkg::status_type rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   assign word      = s2b_pkg::ucode_rom(step_ff);
   assign busy      = word.busy;
   assign accept    = start && !word.busy;
   assign csr_ready = 1'b1;

   assign m_sec   = bsize_ff[16:s2b_pkg::SECTOR_SHIFT];
   assign bs_bad  = (bsize_ff[s2b_pkg::SECTOR_SHIFT-1:0] != '0) || (m_sec == 8'd0) ||
                    (bsize_ff[16] && (bsize_ff[15:s2b_pkg::SECTOR_SHIFT] != '0));
   assign end_sum = {1'b0, start_ff} + {26'd0, count_ff};
   assign bad     = !dev_ff || (count_ff == 7'd0) || (count_ff > 7'(MAX_SECTORS)) ||
                    bs_bad || end_sum[32] || (end_sum[31:0] > total_ff);

   assign shifted = {r_ff, q_ff[31]};
   assign ge      = shifted >= m_sec;

   assign avail   = m_sec - {1'b0, r_ff};
   assign rem_ext = 8'(rem_ff);
   assign take8   = (rem_ext < avail) ? rem_ext : avail;
   assign take    = RW'(take8);
   assign beyond  = q_ff >= bcount_ff;
   assign run_end = beyond || (rem_ext <= avail);

   always_comb begin
      case (word.cond)
         s2b_pkg::COND_ALWAYS:   cond_hit = 1'b1;
         s2b_pkg::COND_START:    cond_hit = start;
         s2b_pkg::COND_BAD:      cond_hit = bad;
         s2b_pkg::COND_DIV_MORE: cond_hit = (cnt_ff != 5'd31);
         s2b_pkg::COND_RUN_MORE: cond_hit = !run_end;
         default:                cond_hit = 1'b0;
      endcase
      step_in = cond_hit ? word.jmp : word.nxt;
   end

   always_comb begin
      q_in   = q_ff;
      r_in   = r_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      if (word.div_init) begin
         q_in   = start_ff;
         r_in   = '0;
         cnt_in = '0;
         rem_in = RW'(count_ff);
      end else if (word.div_step) begin
         q_in   = {q_ff[30:0], ge};
         r_in   = ge ? 7'(shifted - m_sec) : 7'(shifted);
         cnt_in = cnt_ff + 5'd1;
      end else if (word.emit_blk) begin
         q_in   = q_ff + 32'd1;
         r_in   = '0;
         rem_in = rem_ff - take;
      end
   end

   always_comb begin
      rsp_valid_in  = word.emit_blk || word.emit_rej;
      rsp_block_in  = '0;
      rsp_offset_in = '0;
      rsp_take_in   = '0;
      rsp_status_in = s2b_pkg::STATUS_REJECT;
      rsp_last_in   = 1'b1;
      if (word.emit_blk) begin
         rsp_block_in  = q_ff;
         rsp_offset_in = 16'({r_ff, 9'd0});
         if (beyond) begin
            rsp_status_in = s2b_pkg::STATUS_BEYOND;
         end else begin
            rsp_take_in   = 16'({take, 9'd0});
            rsp_status_in = s2b_pkg::STATUS_BLOCK;
            rsp_last_in   = rem_ext <= avail;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= s2b_pkg::STEP_IDLE;
         rsp_valid_ff <= 1'b0;
         dev_ff       <= 1'b0;
         bsize_ff     <= 17'd2048;
         bcount_ff    <= '0;
         total_ff     <= '0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               s2b_pkg::CSR_DEVICE_PRESENT: dev_ff    <= csr_wdata[0];
               s2b_pkg::CSR_MEDIA_BSIZE:    bsize_ff  <= csr_wdata[16:0];
               s2b_pkg::CSR_MEDIA_BLOCKS:   bcount_ff <= csr_wdata;
               s2b_pkg::CSR_TOTAL_SECTORS:  total_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         start_ff <= req_start_sector;
         count_ff <= req_sector_count;
      end
      q_ff          <= q_in;
      r_ff          <= r_in;
      cnt_ff        <= cnt_in;
      rem_ff        <= rem_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_take_ff   <= rsp_take_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_block_number = rsp_block_ff;
   assign rsp_byte_offset  = rsp_offset_ff;
   assign rsp_byte_take    = rsp_take_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_last         = rsp_last_ff;

   `S2B_ASSERT(a_accept_then_busy, clock, reset, accept |=> busy)
   `S2B_ASSERT(a_rsp_from_busy_step, clock, reset, rsp_valid_ff |-> $past(word.busy))
   `S2B_ASSERT(a_reject_is_last, clock, reset,
      (rsp_valid_ff && (rsp_status_ff == s2b_pkg::STATUS_REJECT)) |-> rsp_last_ff)
   `S2B_ASSERT_NEVER(a_block_take_zero, clock, reset,
      rsp_valid_ff && (rsp_status_ff == s2b_pkg::STATUS_BLOCK) && (rsp_take_ff == 16'd0))

endmodule
`default_nettype wire
